FILE: rtl/fcdl_pkg.sv
// ---------------------------------------------------------------------------
// fcdl_pkg
// Shared types, codes and the sequencer program for the FIR filter core.
// ---------------------------------------------------------------------------
package fcdl_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int TAP_INDEX_W = 6;
  localparam int PROD_W      = 2 * SAMPLE_W;
  localparam int FRAC_BITS   = 15;
  localparam int ROUND_HALF  = 1 << (FRAC_BITS - 1);
  localparam int OUT_MAX     = 32767;
  localparam int OUT_MIN     = -32768;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_DRAIN1,
    S_DRAIN2,
    S_ROUND
  } step_t;

  typedef enum logic [1:0] {
    C_ALWAYS,
    C_SAMPLE,
    C_LAST,
    C_OUT_FREE
  } cond_t;

  // One control word: strobes for the datapath, a jump condition, the step
  // taken when the condition holds and the step taken when it does not.
  typedef struct packed {
    logic  accept;
    logic  issue;
    logic  finish;
    cond_t cond;
    step_t jump;
    step_t seq;
  } ucode_t;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    case (s)
      S_IDLE:   w = '{accept: 1'b1, issue: 1'b0, finish: 1'b0,
                      cond: C_SAMPLE, jump: S_FILL, seq: S_IDLE};
      S_FILL:   w = '{accept: 1'b0, issue: 1'b1, finish: 1'b0,
                      cond: C_LAST, jump: S_DRAIN1, seq: S_FILL};
      S_DRAIN1: w = '{accept: 1'b0, issue: 1'b0, finish: 1'b0,
                      cond: C_ALWAYS, jump: S_DRAIN2, seq: S_DRAIN2};
      S_DRAIN2: w = '{accept: 1'b0, issue: 1'b0, finish: 1'b0,
                      cond: C_ALWAYS, jump: S_ROUND, seq: S_ROUND};
      S_ROUND:  w = '{accept: 1'b0, issue: 1'b0, finish: 1'b1,
                      cond: C_OUT_FREE, jump: S_IDLE, seq: S_ROUND};
      default:  w = '{accept: 1'b0, issue: 1'b0, finish: 1'b0,
                      cond: C_ALWAYS, jump: S_IDLE, seq: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/fcdl_if.sv
// ---------------------------------------------------------------------------
// fcdl_in_if / fcdl_out_if
// Valid/ready channels for filter input beats and filtered result beats.
// ---------------------------------------------------------------------------
interface fcdl_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [15:0] sample_in;
  logic        [5:0]  tap_index;
  logic signed [15:0] tap_value;

  modport source (output valid, mode, sample_in, tap_index, tap_value, input ready);
  modport sink   (input valid, mode, sample_in, tap_index, tap_value, output ready);
endinterface

interface fcdl_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  logic               clipped;

  modport source (output valid, sample_out, clipped, input ready);
  modport sink   (input valid, sample_out, clipped, output ready);
endinterface

FILE: rtl/fcdl_ram.sv
// ---------------------------------------------------------------------------
// fcdl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module fcdl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/fir_filter_circular_delay_line_core.sv
// ---------------------------------------------------------------------------
// fir_filter_circular_delay_line_core
// Direct-form FIR filter over a circular delay line, run by a small
// microcoded sequencer around one shared multiply-accumulate unit.
//
// A beat with mode 0 writes its sample into the delay line and starts one
// pass over all TAPS taps: one tap is read from the coefficient and sample
// RAMs per cycle, multiplied and added to a wide exact accumulator. The
// result is rounded half up to Q1.15, saturated to 16 bits with the
// clipped flag, and placed in the output register. A sample beat occupies
// the input through the accept step, TAPS reads, two pipeline drain steps
// and the round step, set by the single RAM read port per store; the round
// step holds while a previous result still waits. A beat with mode 1 writes
// one coefficient and gives no result; indexes at or above TAPS are
// dropped. Both stores read as zero until written, through per-entry valid
// bits, so no clearing pass follows reset.
// ---------------------------------------------------------------------------
module fir_filter_circular_delay_line_core
  import fcdl_pkg::*;
#(
  parameter int TAPS = 64
) (
  input  logic        clk,
  input  logic        rst,
  fcdl_in_if.sink     samples,
  fcdl_out_if.source  results
);

  localparam int AW    = $clog2(TAPS);
  localparam int ACC_W = PROD_W + AW;

  step_t  step, step_next;
  ucode_t uw;
  logic   cond_true;
  logic   out_free;
  logic   load_out;
  logic   beat;
  logic   sample_beat;
  logic   coef_beat;
  logic   coef_in_range;

  logic [AW-1:0] wp;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] tap_cnt;
  logic          tap_last;

  logic [TAPS-1:0] dl_valid;
  logic [TAPS-1:0] tp_valid;
  logic            dl_vq;
  logic            tp_vq;
  logic            rd_v;
  logic            prod_v;

  logic [SAMPLE_W-1:0]        dl_rdata;
  logic [SAMPLE_W-1:0]        tp_rdata;
  logic signed [SAMPLE_W-1:0] x_val;
  logic signed [SAMPLE_W-1:0] h_val;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    rnd;
  logic signed [ACC_W-1:0]    y;

  logic               out_valid;
  logic signed [15:0] sample_out;
  logic               clipped;

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  assign uw       = ucode_rom(step);
  assign out_free = !out_valid || results.ready;
  assign tap_last = (tap_cnt == AW'(TAPS - 1));

  assign beat          = samples.valid && samples.ready;
  assign sample_beat   = beat && (samples.mode == MODE_SAMPLE);
  assign coef_beat     = beat && (samples.mode == MODE_COEF);
  assign coef_in_range = (32'(samples.tap_index) < TAPS);

  always_comb begin
    case (uw.cond)
      C_ALWAYS:   cond_true = 1'b1;
      C_SAMPLE:   cond_true = sample_beat;
      C_LAST:     cond_true = tap_last;
      C_OUT_FREE: cond_true = out_free;
      default:    cond_true = 1'b0;
    endcase
    step_next = cond_true ? uw.jump : uw.seq;
  end

  always_comb begin
    samples.ready = uw.accept;
    load_out      = uw.finish && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // -------------------------------------------------------------------------
  // Pointers and valid bits
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      dl_valid <= '0;
      tp_valid <= '0;
    end else begin
      if (sample_beat) begin
        dl_valid[wp] <= 1'b1;
        wp           <= (wp == AW'(TAPS - 1)) ? '0 : wp + 1'b1;
      end
      if (coef_beat && coef_in_range) begin
        tp_valid[AW'(samples.tap_index)] <= 1'b1;
      end
    end
  end

  // Walk the taps: coefficient n pairs with the sample written n beats ago.
  always_ff @(posedge clk) begin
    if (sample_beat) begin
      tap_cnt <= '0;
      rd_ptr  <= wp;
    end else if (uw.issue) begin
      tap_cnt <= tap_cnt + 1'b1;
      rd_ptr  <= (rd_ptr == '0) ? AW'(TAPS - 1) : rd_ptr - 1'b1;
    end
  end

  fcdl_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_delay_ram (
    .clk   (clk),
    .we    (sample_beat),
    .waddr (wp),
    .wdata (samples.sample_in),
    .re    (uw.issue),
    .raddr (rd_ptr),
    .rdata (dl_rdata)
  );

  fcdl_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_tap_ram (
    .clk   (clk),
    .we    (coef_beat && coef_in_range),
    .waddr (AW'(samples.tap_index)),
    .wdata (samples.tap_value),
    .re    (uw.issue),
    .raddr (tap_cnt),
    .rdata (tp_rdata)
  );

  // -------------------------------------------------------------------------
  // Multiply-accumulate pipeline
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v   <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      rd_v   <= uw.issue;
      prod_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.issue) begin
      dl_vq <= dl_valid[rd_ptr];
      tp_vq <= tp_valid[tap_cnt];
    end
  end

  // Entries never written read as zero.
  assign x_val = dl_vq ? signed'(dl_rdata) : '0;
  assign h_val = tp_vq ? signed'(tp_rdata) : '0;

  always_ff @(posedge clk) begin
    if (rd_v) begin
      prod <= x_val * h_val;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_beat) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // -------------------------------------------------------------------------
  // Round, saturate and hold the result
  // -------------------------------------------------------------------------
  assign rnd = acc + ACC_W'(ROUND_HALF);
  assign y   = rnd >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (y > ACC_W'(OUT_MAX)) begin
        sample_out <= 16'(OUT_MAX);
        clipped    <= 1'b1;
      end else if (y < ACC_W'(OUT_MIN)) begin
        sample_out <= 16'(OUT_MIN);
        clipped    <= 1'b1;
      end else begin
        sample_out <= y[15:0];
        clipped    <= 1'b0;
      end
    end
  end

  assign results.valid      = out_valid;
  assign results.sample_out = sample_out;
  assign results.clipped    = clipped;

`ifndef SYNTHESIS
  // The pipeline must be empty when the sum is rounded.
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (step == S_ROUND) |-> (!rd_v && !prod_v))
    else $error("rounding with products still in flight");

  a_start: assert property (@(posedge clk) disable iff (rst)
    sample_beat |=> (step == S_FILL) && (tap_cnt == '0) && (acc == '0))
    else $error("tap walk did not start cleanly");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> ($past(step) == S_ROUND))
    else $error("result appeared outside the round step");

  a_wp_wrap: assert property (@(posedge clk) disable iff (rst)
    sample_beat |=> (($past(wp) == AW'(TAPS - 1)) ? (wp == '0)
                                                 : (wp == $past(wp) + 1'b1)))
    else $error("write pointer did not advance by one");
`endif

endmodule
